// ----- hw/rtl/cfe_pkg.sv -----
`default_nettype none

package cfe_pkg;

  localparam int unsigned BYTE_W = 8;

  localparam logic [BYTE_W-1:0] TERM_BYTE = 8'h00;

  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h00;

endpackage

`default_nettype wire

// ----- hw/rtl/cfe_group_ram.sv -----
`default_nettype none

module cfe_group_ram
  import cfe_pkg::*;
#(
  parameter int unsigned Depth = 60,
  parameter int unsigned AddrW = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AddrW-1:0]  waddr_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  input  wire logic [AddrW-1:0]  raddr_i,
  output logic      [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/cobs_frame_encoder.sv -----
// COBS frame encoder, group bytes held in a one-port-write, one-port-read RAM.
// A buffered byte gives no output; a closed group of n bytes gives n + 1 output
// bytes, one per cycle while the output is not stalled by m_axis_tready, then the
// terminator if the message ended. The next request is taken once the last byte of
// the current one is in the output register. Reset (async, active low) clears all
// control state and sets the delimiter to 0x00; RAM contents are not cleared.
`default_nettype none

module cobs_frame_encoder
  import cfe_pkg::*;
#(
  parameter int unsigned MAX_LEN = 60
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration: delimiter value
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [BYTE_W-1:0] cfg_data_i,
  // input stream
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [BYTE_W-1:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic              s_axis_tlast_i,
  // output stream
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic      [BYTE_W-1:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic                   m_axis_tlast_o,
  output logic      [1:0]        m_axis_tuser_o    // [0] frame_end, [1] overflow
);

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);
  localparam int unsigned IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LEN);

  typedef enum logic [2:0] {
    StIdle,
    StCode,
    StData,
    StTerm
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   gcnt_q, gcnt_d;
  logic [CntW-1:0]   msg_q, msg_d;
  logic [CntW-1:0]   len_q, len_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              ovf_q, ovf_d;
  logic              second_q, second_d;
  logic              final_q, final_d;
  logic [BYTE_W-1:0] delim_q;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_last_q;
  logic              out_fe_q;
  logic              out_ovf_q;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic [BYTE_W-1:0] load_byte;
  logic              load_last;
  logic              load_fe;
  logic              more;
  logic              last_el;
  logic              mem_we;
  logic [BYTE_W-1:0] mem_rdata;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign more            = second_q | final_q;
  assign last_el         = ((CntW'(idx_q) + CntW'(1)) == len_q);

  cfe_group_ram #(
    .Depth (MAX_LEN),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (gcnt_q[IdxW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (idx_d),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d   = state_q;
    gcnt_d    = gcnt_q;
    msg_d     = msg_q;
    len_d     = len_q;
    idx_d     = idx_q;
    ovf_d     = ovf_q;
    second_d  = second_q;
    final_d   = final_q;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    load_byte = TERM_BYTE;
    load_last = 1'b0;
    load_fe   = 1'b0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          idx_d = '0;
          if (msg_q >= MaxCnt) begin
            ovf_d = 1'b1;
            if (s_axis_tlast_i) begin
              len_d    = gcnt_q;
              gcnt_d   = '0;
              final_d  = 1'b1;
              second_d = 1'b0;
              state_d  = StCode;
            end
          end else begin
            msg_d = msg_q + CntW'(1);
            if (s_axis_tdata_i == delim_q) begin
              len_d    = gcnt_q;
              gcnt_d   = '0;
              second_d = s_axis_tlast_i;
              final_d  = 1'b0;
              state_d  = StCode;
            end else begin
              mem_we = 1'b1;
              gcnt_d = gcnt_q + CntW'(1);
              if (s_axis_tlast_i) begin
                len_d    = gcnt_q + CntW'(1);
                gcnt_d   = '0;
                final_d  = 1'b1;
                second_d = 1'b0;
                state_d  = StCode;
              end
            end
          end
        end
      end

      StCode: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_byte = BYTE_W'(len_q) + BYTE_W'(1);
          load_last = (len_q == '0) & ~more;
          idx_d     = '0;
          if (len_q != '0) begin
            state_d = StData;
          end else if (second_q) begin
            second_d = 1'b0;
            final_d  = 1'b1;
            len_d    = '0;
            state_d  = StCode;
          end else if (final_q) begin
            state_d = StTerm;
          end else begin
            state_d = StIdle;
          end
        end
      end

      StData: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_byte = mem_rdata;
          load_last = last_el & ~more;
          idx_d     = last_el ? '0 : idx_q + IdxW'(1);
          if (last_el) begin
            if (second_q) begin
              second_d = 1'b0;
              final_d  = 1'b1;
              len_d    = '0;
              state_d  = StCode;
            end else if (final_q) begin
              state_d = StTerm;
            end else begin
              state_d = StIdle;
            end
          end
        end
      end

      StTerm: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_byte = TERM_BYTE;
          load_last = 1'b1;
          load_fe   = 1'b1;
          msg_d     = '0;
          gcnt_d    = '0;
          ovf_d     = 1'b0;
          final_d   = 1'b0;
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      gcnt_q      <= '0;
      msg_q       <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      second_q    <= 1'b0;
      final_q     <= 1'b0;
      delim_q     <= DELIM_RESET;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
      out_fe_q    <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      gcnt_q   <= gcnt_d;
      msg_q    <= msg_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      ovf_q    <= ovf_d;
      second_q <= second_d;
      final_q  <= final_d;
      if (cfg_valid_i) begin
        delim_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_byte_q  <= load_byte;
        out_last_q  <= load_last;
        out_fe_q    <= load_fe;
        out_ovf_q   <= ovf_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = {out_ovf_q, out_fe_q};

endmodule

`default_nettype wire

// ----- tb/tb_cobs_frame_encoder.sv -----
`timescale 1ns / 100ps

module tb_cobs_frame_encoder;
  import cfe_pkg::*;

  localparam int MAX_LEN = 60;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              hold;
  } raw_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              run_last;
    logic              frame_end;
    logic              ovf;
  } enc_byte_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [BYTE_W-1:0] cfg_data = '0;
  logic              cfg_ready;
  logic              s_tvalid = 1'b0;
  logic [BYTE_W-1:0] s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              s_tready;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [BYTE_W-1:0] m_tdata;
  logic              m_tlast;
  logic [1:0]        m_tuser;

  raw_req_t  raw_q[$];
  enc_byte_t frame_q[$];

  // encoder state as predicted
  logic [BYTE_W-1:0] grp_buf [MAX_LEN];
  int                grp_len = 0;
  int                msg_len = 0;
  logic              drop_seen = 1'b0;
  logic [BYTE_W-1:0] delim_cur = DELIM_RESET;

  logic [BYTE_W-1:0] gen_delim = DELIM_RESET;
  logic [BYTE_W-1:0] mid_delim;
  int                src_idle = 0;
  int                sink_idle = 0;
  bit                in_taken = 1'b0;
  enc_byte_t         want;
  int                errors = 0;
  int                cycles = 0;
  int                bytes_in = 0;
  int                bytes_out = 0;
  int                bytes_dropped = 0;
  int                msgs_done = 0;

  cobs_frame_encoder #(.MAX_LEN(MAX_LEN)) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    $display("[%0t] mismatch %s: got 0x%02h, expected 0x%02h", $time, what, got, exp_val);
    errors++;
  endtask

  function automatic void emit_byte(input logic [BYTE_W-1:0] value, input logic is_end);
    enc_byte_t e;
    e.code      = value;
    e.run_last  = 1'b0;
    e.frame_end = is_end;
    e.ovf       = drop_seen;
    frame_q.push_back(e);
  endfunction

  function automatic void flush_group();
    emit_byte(BYTE_W'((grp_len + 1) & 'hFF), 1'b0);
    for (int i = 0; i < grp_len; i++) emit_byte(grp_buf[i], 1'b0);
    grp_len = 0;
  endfunction

  function automatic void cobs_step(input logic [BYTE_W-1:0] b, input logic is_last);
    int        n0;
    enc_byte_t e;
    n0 = frame_q.size();
    bytes_in++;
    if (msg_len >= MAX_LEN) begin
      drop_seen = 1'b1;
      bytes_dropped++;
    end else begin
      msg_len++;
      if (b == delim_cur) begin
        flush_group();
      end else if (grp_len < MAX_LEN) begin
        grp_buf[grp_len] = b;
        grp_len++;
      end
    end
    if (is_last) begin
      flush_group();
      emit_byte(TERM_BYTE, 1'b1);
      msg_len   = 0;
      drop_seen = 1'b0;
      msgs_done++;
    end
    if (frame_q.size() > n0) begin
      e = frame_q.pop_back();
      e.run_last = 1'b1;
      frame_q.push_back(e);
    end
  endfunction

  // request driver and output ready driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_idle);
      if (!s_tvalid || in_taken) begin
        in_taken = 1'b0;
        if (raw_q.size() > 0 && !(raw_q[0].hold && frame_q.size() > 0) &&
            $urandom_range(0, 99) >= src_idle) begin
          s_tvalid <= 1'b1;
          s_tdata  <= raw_q[0].data;
          s_tlast  <= raw_q[0].last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) delim_cur = cfg_data;
      if (m_tvalid && m_tready) begin
        bytes_out++;
        if (frame_q.size() == 0) begin
          report_mismatch("unexpected out_byte", m_tdata, 8'h00);
        end else begin
          want = frame_q.pop_front();
          if (m_tdata !== want.code) report_mismatch("out_byte", m_tdata, want.code);
          if (m_tlast !== want.run_last)
            report_mismatch("run_last", 8'(m_tlast), 8'(want.run_last));
          if (m_tuser[0] !== want.frame_end)
            report_mismatch("frame_end", 8'(m_tuser[0]), 8'(want.frame_end));
          if (m_tuser[1] !== want.ovf)
            report_mismatch("overflow", 8'(m_tuser[1]), 8'(want.ovf));
        end
      end
      if (s_tvalid && s_tready) begin
        cobs_step(s_tdata, s_tlast);
        raw_q.delete(0);
        in_taken = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_req(input logic [BYTE_W-1:0] data, input logic last);
    raw_q.push_back('{data, last, 1'b0});
  endtask

  task automatic drain();
    while (raw_q.size() > 0 || s_tvalid) @(posedge clk_i);
    while (frame_q.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_delim(input logic [BYTE_W-1:0] v);
    gen_delim = v;
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // delim_pct of zero keeps the delimiter out of the message
  task automatic queue_message(input int len, input int delim_pct, input bit hold_first);
    raw_req_t r;
    for (int i = 0; i < len; i++) begin
      if (delim_pct > 0 && $urandom_range(0, 99) < delim_pct) begin
        r.data = gen_delim;
      end else begin
        r.data = BYTE_W'($urandom_range(0, 255));
        while (delim_pct == 0 && r.data == gen_delim) r.data = BYTE_W'($urandom_range(0, 255));
      end
      r.last = (i == len - 1);
      r.hold = hold_first && (i == 0);
      raw_q.push_back(r);
    end
  endtask

  // the long message waits until every earlier result has come out
  task automatic run_phase(input int src, input int sink, input logic [BYTE_W-1:0] delim,
                           input int long_len, input int long_pct, input int budget);
    int n;
    int len;
    drain();
    src_idle  = src;
    sink_idle = sink;
    write_delim(delim);
    n = 0;
    while (n < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
      queue_message(len, 25, 1'b0);
      n += len;
    end
    if (long_len > 0) queue_message(long_len, long_pct, 1'b1);
  endtask

  initial begin
    src_idle  = 22;
    sink_idle = 50;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // delimiter 0x00: lone delimiter, trailing delimiter, back-to-back delimiters
    write_delim(8'h00);
    push_req(8'h00, 1'b1);
    push_req(8'hFF, 1'b0);
    push_req(8'h00, 1'b0);
    push_req(8'h01, 1'b0);
    push_req(8'h00, 1'b1);
    push_req(8'h00, 1'b0);
    push_req(8'h00, 1'b1);
    push_req(8'h80, 1'b1);
    drain();

    // delimiter 0xFF: zero bytes are plain data
    write_delim(8'hFF);
    push_req(8'hFF, 1'b1);
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'h7F, 1'b1);
    drain();

    // delimiter 0x03: a two-byte group gives a code equal to the delimiter
    write_delim(8'h03);
    push_req(8'h11, 1'b0);
    push_req(8'h22, 1'b0);
    push_req(8'h03, 1'b0);
    push_req(8'h44, 1'b0);
    push_req(8'h55, 1'b1);
    push_req(8'h03, 1'b1);

    mid_delim = BYTE_W'($urandom_range(1, 254));
    // full group then a dropped last byte; short messages only;
    // overflow across several groups
    run_phase(22, 50, 8'hFF, 61, 0, 4);
    run_phase(50, 22, mid_delim, 0, 0, 6);
    run_phase(0, 0, 8'h00, 61, 20, 4);
    drain();
    repeat (16) @(posedge clk_i);

    if (frame_q.size() != 0)
      report_mismatch("results never received", 8'(frame_q.size()), 8'h00);
    $display("covered %0d messages: %0d bytes in, %0d frame bytes out, %0d dropped as too long",
             msgs_done, bytes_in, bytes_out, bytes_dropped);
    $display("delimiters 0x00, 0xff, 0x03 and 0x%02h; %0d mismatches", mid_delim, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/cfe_pkg.sv
hw/rtl/cfe_group_ram.sv
hw/rtl/cobs_frame_encoder.sv
tb/tb_cobs_frame_encoder.sv
